/* rtl/scp_pkg.sv */
// Shared types and constants for the shape pair collision test.
// No dependencies; imported by every module of the block.
package scp_pkg;

  typedef enum logic [1:0] {
    KIND_CIRCLE  = 2'd0,
    KIND_RECT    = 2'd1,
    KIND_TRI     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TEST_CC   = 2'd0,
    TEST_CR   = 2'd1,
    TEST_BOX  = 2'd2,
    TEST_NONE = 2'd3
  } test_e;

  // sqrt(3)/3 as an unsigned 32-bit fraction
  localparam int unsigned TRI_K_W = 32;
  localparam logic [TRI_K_W-1:0] TRI_K = 32'd2479700524;

endpackage

/* rtl/scp_prep.sv */
// First compute stage: picks the test, forms the distance operands for the
// squared tests and the box extents of both shapes. Depends on scp_pkg.
module scp_prep #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  scp_pkg::kind_e                 a_kind_i,
  input  logic signed [COORD_WIDTH-1:0]  a_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_y_i,
  input  logic        [COORD_WIDTH-2:0]  a_size_i,
  input  logic        [COORD_WIDTH-2:0]  a_height_i,
  input  scp_pkg::kind_e                 b_kind_i,
  input  logic signed [COORD_WIDTH-1:0]  b_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_y_i,
  input  logic        [COORD_WIDTH-2:0]  b_size_i,
  input  logic        [COORD_WIDTH-2:0]  b_height_i,
  output scp_pkg::test_e                 test_o,
  output logic        [COORD_WIDTH+1:0]  mag_x_o,
  output logic        [COORD_WIDTH+1:0]  mag_y_o,
  output logic        [COORD_WIDTH-1:0]  rr_o,
  output logic        [COORD_WIDTH-1:0]  a_ex_o,
  output logic        [COORD_WIDTH-1:0]  a_ey0_o,
  output logic        [COORD_WIDTH-1:0]  a_ey1_o,
  output logic        [COORD_WIDTH-1:0]  b_ex_o,
  output logic        [COORD_WIDTH-1:0]  b_ey0_o,
  output logic        [COORD_WIDTH-1:0]  b_ey1_o
);
  import scp_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = COORD_WIDTH - 1 + TRI_K_W;

  // distance from p to the interval [lo, hi], zero inside
  function automatic logic [CW+1:0] axis_gap(input logic signed [CW+2:0] p,
                                             input logic signed [CW+2:0] lo,
                                             input logic signed [CW+2:0] hi);
    logic signed [CW+2:0] d;
    if (p < lo) begin
      d = lo - p;
    end else if (p > hi) begin
      d = p - hi;
    end else begin
      d = '0;
    end
    return d[CW+1:0];
  endfunction

  function automatic logic [CW-1:0] ext_x(input kind_e k, input logic [CW-2:0] s);
    return (k == KIND_CIRCLE) ? {s, 1'b0} : {1'b0, s};
  endfunction

  function automatic logic [CW-1:0] ext_y0(input kind_e k, input logic [CW-2:0] s,
                                           input logic [CW-2:0] h,
                                           input logic [PW-1:0] p);
    logic [CW-1:0] e;
    case (k)
      KIND_CIRCLE: e = {s, 1'b0};
      KIND_RECT:   e = {1'b0, h};
      default:     e = {1'b0, p[PW-1:TRI_K_W]};
    endcase
    return e;
  endfunction

  function automatic logic [CW-1:0] ext_y1(input kind_e k, input logic [CW-2:0] s,
                                           input logic [CW-2:0] h,
                                           input logic [PW-1:0] p);
    logic [CW-1:0] e;
    case (k)
      KIND_CIRCLE: e = {s, 1'b0};
      KIND_RECT:   e = {1'b0, h};
      default:     e = p[PW-1:TRI_K_W-1];
    endcase
    return e;
  endfunction

  test_e                test;
  logic [CW:0]          cc_dx, cc_dy, cc_mx, cc_my;
  logic [CW-1:0]        cc_rs;
  logic                 swap;
  logic signed [CW-1:0] c_x, c_y, r_x, r_y;
  logic [CW-2:0]        c_size, r_size, r_height;
  logic signed [CW+2:0] px, py, rx, ry, rw, rh;
  logic [CW+1:0]        cr_mx, cr_my;
  logic [PW-1:0]        a_prod, b_prod;

  always_comb begin
    if (a_kind_i == KIND_UNKNOWN || b_kind_i == KIND_UNKNOWN) begin
      test = TEST_NONE;
    end else if (a_kind_i == KIND_CIRCLE && b_kind_i == KIND_CIRCLE) begin
      test = TEST_CC;
    end else if ((a_kind_i == KIND_CIRCLE && b_kind_i == KIND_RECT) ||
                 (a_kind_i == KIND_RECT && b_kind_i == KIND_CIRCLE)) begin
      test = TEST_CR;
    end else begin
      test = TEST_BOX;
    end
  end

  // circle against circle, plain coordinates
  assign cc_dx = {a_x_i[CW-1], a_x_i} - {b_x_i[CW-1], b_x_i};
  assign cc_dy = {a_y_i[CW-1], a_y_i} - {b_y_i[CW-1], b_y_i};
  assign cc_mx = cc_dx[CW] ? (~cc_dx + 1'b1) : cc_dx;
  assign cc_my = cc_dy[CW] ? (~cc_dy + 1'b1) : cc_dy;
  assign cc_rs = {1'b0, a_size_i} + {1'b0, b_size_i};

  // circle against rectangle, doubled coordinates
  assign swap     = (a_kind_i == KIND_RECT);
  assign c_x      = swap ? b_x_i : a_x_i;
  assign c_y      = swap ? b_y_i : a_y_i;
  assign c_size   = swap ? b_size_i : a_size_i;
  assign r_x      = swap ? a_x_i : b_x_i;
  assign r_y      = swap ? a_y_i : b_y_i;
  assign r_size   = swap ? a_size_i : b_size_i;
  assign r_height = swap ? a_height_i : b_height_i;

  assign px = $signed({{2{c_x[CW-1]}}, c_x, 1'b0});
  assign py = $signed({{2{c_y[CW-1]}}, c_y, 1'b0});
  assign rx = $signed({{2{r_x[CW-1]}}, r_x, 1'b0});
  assign ry = $signed({{2{r_y[CW-1]}}, r_y, 1'b0});
  assign rw = $signed({4'b0, r_size});
  assign rh = $signed({4'b0, r_height});

  assign cr_mx = axis_gap(px, rx - rw, rx + rw);
  assign cr_my = axis_gap(py, ry - rh, ry + rh);

  assign test_o  = test;
  assign mag_x_o = (test == TEST_CC) ? {1'b0, cc_mx} : cr_mx;
  assign mag_y_o = (test == TEST_CC) ? {1'b0, cc_my} : cr_my;
  assign rr_o    = (test == TEST_CC) ? cc_rs : {c_size, 1'b0};

  // triangle height extents
  assign a_prod = PW'(a_size_i) * PW'(TRI_K);
  assign b_prod = PW'(b_size_i) * PW'(TRI_K);

  assign a_ex_o  = ext_x(a_kind_i, a_size_i);
  assign a_ey0_o = ext_y0(a_kind_i, a_size_i, a_height_i, a_prod);
  assign a_ey1_o = ext_y1(a_kind_i, a_size_i, a_height_i, a_prod);
  assign b_ex_o  = ext_x(b_kind_i, b_size_i);
  assign b_ey0_o = ext_y0(b_kind_i, b_size_i, b_height_i, b_prod);
  assign b_ey1_o = ext_y1(b_kind_i, b_size_i, b_height_i, b_prod);

endmodule

/* rtl/scp_eval.sv */
// Second compute stage: squares the distance operands and runs the
// inclusive bounding box overlap test. Depends on scp_pkg.
module scp_eval #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic        [COORD_WIDTH+1:0]   mag_x_i,
  input  logic        [COORD_WIDTH+1:0]   mag_y_i,
  input  logic        [COORD_WIDTH-1:0]   rr_i,
  input  logic signed [COORD_WIDTH-1:0]   a_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_y_i,
  input  logic        [COORD_WIDTH-1:0]   a_ex_i,
  input  logic        [COORD_WIDTH-1:0]   a_ey0_i,
  input  logic        [COORD_WIDTH-1:0]   a_ey1_i,
  input  logic signed [COORD_WIDTH-1:0]   b_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_y_i,
  input  logic        [COORD_WIDTH-1:0]   b_ex_i,
  input  logic        [COORD_WIDTH-1:0]   b_ey0_i,
  input  logic        [COORD_WIDTH-1:0]   b_ey1_i,
  output logic        [2*COORD_WIDTH+3:0] sq_x_o,
  output logic        [2*COORD_WIDTH+3:0] sq_y_o,
  output logic        [2*COORD_WIDTH-1:0] sq_r_o,
  output logic                            box_hit_o
);
  import scp_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  function automatic logic signed [CW+1:0] dbl(input logic signed [CW-1:0] v);
    return $signed({v[CW-1], v, 1'b0});
  endfunction

  function automatic logic signed [CW+1:0] ext(input logic [CW-1:0] e);
    return $signed({2'b0, e});
  endfunction

  logic signed [CW+1:0] a_x0, a_x1, a_y0, a_y1;
  logic signed [CW+1:0] b_x0, b_x1, b_y0, b_y1;

  assign sq_x_o = {{(CW+2){1'b0}}, mag_x_i} * {{(CW+2){1'b0}}, mag_x_i};
  assign sq_y_o = {{(CW+2){1'b0}}, mag_y_i} * {{(CW+2){1'b0}}, mag_y_i};
  assign sq_r_o = {{CW{1'b0}}, rr_i} * {{CW{1'b0}}, rr_i};

  assign a_x0 = dbl(a_x_i) - ext(a_ex_i);
  assign a_x1 = dbl(a_x_i) + ext(a_ex_i);
  assign a_y0 = dbl(a_y_i) - ext(a_ey0_i);
  assign a_y1 = dbl(a_y_i) + ext(a_ey1_i);
  assign b_x0 = dbl(b_x_i) - ext(b_ex_i);
  assign b_x1 = dbl(b_x_i) + ext(b_ex_i);
  assign b_y0 = dbl(b_y_i) - ext(b_ey0_i);
  assign b_y1 = dbl(b_y_i) + ext(b_ey1_i);

  assign box_hit_o = (a_x0 <= b_x1) && (a_x1 >= b_x0) &&
                     (a_y0 <= b_y1) && (a_y1 >= b_y0);

endmodule

/* rtl/shape_pair_collision_test.sv */
// Top level of the shape pair collision test: handshake, stage registers
// and the final compare. Depends on scp_pkg, scp_prep and scp_eval.
//
// Narrow-phase collision test for pairs of 2D shapes. One pair is taken per
// cycle unless a stalled output has filled the stages; answers leave in order.
// The path is input register, operand stage (differences, clamping, the
// triangle extent multiply), square stage (three squaring multipliers and
// the box overlap), then the compare of the squared sums into the output
// register. Each stage moves on as soon as the one behind it is free, so
// bubbles are squeezed out while the output is stalled; ready is a short
// combinational chain back from out_ready_i. Coordinates are signed
// two's complement of COORD_WIDTH bits, sizes are unsigned of one bit less;
// the fixed-point scale does not enter any decision.
module shape_pair_collision_test #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    first_kind_i,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic [COORD_WIDTH-2:0]        first_size_i,
  input  logic [COORD_WIDTH-2:0]        first_height_i,
  input  logic [1:0]                    second_kind_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic [COORD_WIDTH-2:0]        second_size_i,
  input  logic [COORD_WIDTH-2:0]        second_height_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          collide_o,
  output logic [1:0]                    test_used_o
);
  import scp_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  // handshake
  logic in_vld_q, pr_vld_q, ev_vld_q, out_vld_q;
  logic in_vld_d, pr_vld_d, ev_vld_d, out_vld_d;
  logic in_rdy, pr_rdy, ev_rdy, out_rdy;

  assign out_rdy = !out_vld_q || out_ready_i;
  assign ev_rdy  = !ev_vld_q || out_rdy;
  assign pr_rdy  = !pr_vld_q || ev_rdy;
  assign in_rdy  = !in_vld_q || pr_rdy;

  always_comb begin
    in_vld_d  = in_rdy  ? in_valid_i : in_vld_q;
    pr_vld_d  = pr_rdy  ? in_vld_q   : pr_vld_q;
    ev_vld_d  = ev_rdy  ? pr_vld_q   : ev_vld_q;
    out_vld_d = out_rdy ? ev_vld_q   : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      pr_vld_q  <= pr_vld_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input register
  kind_e                in_a_kind_q, in_b_kind_q;
  logic signed [CW-1:0] in_a_x_q, in_a_y_q, in_b_x_q, in_b_y_q;
  logic [CW-2:0]        in_a_size_q, in_a_height_q, in_b_size_q, in_b_height_q;

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_a_kind_q   <= kind_e'(first_kind_i);
      in_a_x_q      <= first_x_i;
      in_a_y_q      <= first_y_i;
      in_a_size_q   <= first_size_i;
      in_a_height_q <= first_height_i;
      in_b_kind_q   <= kind_e'(second_kind_i);
      in_b_x_q      <= second_x_i;
      in_b_y_q      <= second_y_i;
      in_b_size_q   <= second_size_i;
      in_b_height_q <= second_height_i;
    end
  end

  // operand stage
  test_e         pr_test;
  logic [CW+1:0] pr_mag_x, pr_mag_y;
  logic [CW-1:0] pr_rr, pr_a_ex, pr_a_ey0, pr_a_ey1, pr_b_ex, pr_b_ey0, pr_b_ey1;

  scp_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .a_kind_i   (in_a_kind_q),
    .a_x_i      (in_a_x_q),
    .a_y_i      (in_a_y_q),
    .a_size_i   (in_a_size_q),
    .a_height_i (in_a_height_q),
    .b_kind_i   (in_b_kind_q),
    .b_x_i      (in_b_x_q),
    .b_y_i      (in_b_y_q),
    .b_size_i   (in_b_size_q),
    .b_height_i (in_b_height_q),
    .test_o     (pr_test),
    .mag_x_o    (pr_mag_x),
    .mag_y_o    (pr_mag_y),
    .rr_o       (pr_rr),
    .a_ex_o     (pr_a_ex),
    .a_ey0_o    (pr_a_ey0),
    .a_ey1_o    (pr_a_ey1),
    .b_ex_o     (pr_b_ex),
    .b_ey0_o    (pr_b_ey0),
    .b_ey1_o    (pr_b_ey1)
  );

  test_e                pr_test_q;
  logic [CW+1:0]        pr_mag_x_q, pr_mag_y_q;
  logic [CW-1:0]        pr_rr_q;
  logic signed [CW-1:0] pr_a_x_q, pr_a_y_q, pr_b_x_q, pr_b_y_q;
  logic [CW-1:0]        pr_a_ex_q, pr_a_ey0_q, pr_a_ey1_q;
  logic [CW-1:0]        pr_b_ex_q, pr_b_ey0_q, pr_b_ey1_q;

  always_ff @(posedge clk_i) begin
    if (pr_rdy && in_vld_q) begin
      pr_test_q  <= pr_test;
      pr_mag_x_q <= pr_mag_x;
      pr_mag_y_q <= pr_mag_y;
      pr_rr_q    <= pr_rr;
      pr_a_x_q   <= in_a_x_q;
      pr_a_y_q   <= in_a_y_q;
      pr_b_x_q   <= in_b_x_q;
      pr_b_y_q   <= in_b_y_q;
      pr_a_ex_q  <= pr_a_ex;
      pr_a_ey0_q <= pr_a_ey0;
      pr_a_ey1_q <= pr_a_ey1;
      pr_b_ex_q  <= pr_b_ex;
      pr_b_ey0_q <= pr_b_ey0;
      pr_b_ey1_q <= pr_b_ey1;
    end
  end

  // square stage
  logic [2*CW+3:0] ev_sq_x, ev_sq_y;
  logic [2*CW-1:0] ev_sq_r;
  logic            ev_box_hit;

  scp_eval #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_eval (
    .mag_x_i   (pr_mag_x_q),
    .mag_y_i   (pr_mag_y_q),
    .rr_i      (pr_rr_q),
    .a_x_i     (pr_a_x_q),
    .a_y_i     (pr_a_y_q),
    .a_ex_i    (pr_a_ex_q),
    .a_ey0_i   (pr_a_ey0_q),
    .a_ey1_i   (pr_a_ey1_q),
    .b_x_i     (pr_b_x_q),
    .b_y_i     (pr_b_y_q),
    .b_ex_i    (pr_b_ex_q),
    .b_ey0_i   (pr_b_ey0_q),
    .b_ey1_i   (pr_b_ey1_q),
    .sq_x_o    (ev_sq_x),
    .sq_y_o    (ev_sq_y),
    .sq_r_o    (ev_sq_r),
    .box_hit_o (ev_box_hit)
  );

  test_e           ev_test_q;
  logic [2*CW+3:0] ev_sq_x_q, ev_sq_y_q;
  logic [2*CW-1:0] ev_sq_r_q;
  logic            ev_box_hit_q;

  always_ff @(posedge clk_i) begin
    if (ev_rdy && pr_vld_q) begin
      ev_test_q    <= pr_test_q;
      ev_sq_x_q    <= ev_sq_x;
      ev_sq_y_q    <= ev_sq_y;
      ev_sq_r_q    <= ev_sq_r;
      ev_box_hit_q <= ev_box_hit;
    end
  end

  // final compare: squared distance strictly below squared reach or box hit
  logic [2*CW+4:0] dist_sum;
  logic            dist_lt;
  logic            hit;

  assign dist_sum = {1'b0, ev_sq_x_q} + {1'b0, ev_sq_y_q};
  assign dist_lt  = dist_sum < {5'b0, ev_sq_r_q};

  always_comb begin
    case (ev_test_q)
      TEST_CC, TEST_CR: hit = dist_lt;
      TEST_BOX:         hit = ev_box_hit_q;
      default:          hit = 1'b0;
    endcase
  end

  logic  collide_q;
  test_e test_q;

  always_ff @(posedge clk_i) begin
    if (out_rdy && ev_vld_q) begin
      collide_q <= hit;
      test_q    <= ev_test_q;
    end
  end

  assign in_ready_o  = in_rdy;
  assign out_valid_o = out_vld_q;
  assign collide_o   = collide_q;
  assign test_used_o = test_q;

endmodule

/* rtl/scp_checker.sv */
// Port-level checks for the shape pair collision test, bound to the top.
// Depends on scp_pkg and shape_pair_collision_test.
module scp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       collide_o,
  input logic [1:0] test_used_o
);
  import scp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(collide_o) &&
                                    $stable(test_used_o))
    else $error("result changed while stalled");

  // unknown kind never reports a hit
  a_none_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && test_used_o == TEST_NONE |-> !collide_o)
    else $error("collision reported with no test");

  // a free output slot means the pipe can take a transfer
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output is free");

  // a fresh result needs an earlier input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 4))
    else $error("result without matching input transfer");

endmodule

bind shape_pair_collision_test scp_checker u_scp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .collide_o   (collide_o),
  .test_used_o (test_used_o)
);
